>>> src/rpb_pkg.sv
// ----------------------------------------------------------------------------
// rpb_pkg
// Types, register indexes and helpers shared by the rotated pixel blender.
// ----------------------------------------------------------------------------
package rpb_pkg;

  localparam int ChanW = 8;
  localparam int NumW  = 16;
  localparam int AddrW = 30;
  localparam int DimW  = 13;

  localparam logic [2:0] REG_FRAME_BASE  = 3'd0;
  localparam logic [2:0] REG_ROW_PITCH   = 3'd1;
  localparam logic [2:0] REG_ROTATE_CW   = 3'd2;
  localparam logic [2:0] REG_CANVAS_W    = 3'd3;
  localparam logic [2:0] REG_CANVAS_H    = 3'd4;

  // word moving through the divider chain
  typedef struct packed {
    logic                       we;
    logic                       opaque;
    logic [AddrW-1:0]           addr;
    logic [31:0]                fc;
    logic [ChanW-1:0]           oa;
    logic [2:0][NumW-1:0]       rem;
    logic [2:0][ChanW-1:0]      quo;
  } rpb_div_t;

  // exact floor(x/255) for x <= 255*255
  function automatic logic [ChanW-1:0] div255(input logic [NumW-1:0] x);
    logic [NumW:0] s;
    s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

>>> src/rpb_div_cell.sv
// ----------------------------------------------------------------------------
// rpb_div_cell
// One restoring-division step for the three color channels, registered.
// ----------------------------------------------------------------------------
module rpb_div_cell import rpb_pkg::*; #(
  parameter int BIT = 7
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rpb_div_t in_word,
  output logic     out_valid,
  input  logic     out_ready,
  output rpb_div_t out_word
);

  rpb_div_t word_next;
  logic [NumW-1:0] dsh;

  assign in_ready = !out_valid || out_ready;
  assign dsh = NumW'({8'd0, in_word.oa} << BIT);

  always_comb begin
    word_next = in_word;
    for (int c = 0; c < 3; c++) begin
      if (in_word.rem[c] >= dsh) begin
        word_next.rem[c]      = in_word.rem[c] - dsh;
        word_next.quo[c][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_word <= word_next;
    end
  end

endmodule

>>> src/argb_rotated_pixel_blend.sv
// ----------------------------------------------------------------------------
// argb_rotated_pixel_blend
// Non-premultiplied ARGB8888 "over" blend with rotated frame addressing.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and returns one result word per
// pixel, in order, through five arithmetic stages (alpha scaling, address
// multiply and add, background alpha scaling, channel numerators) and then
// a chain of eight division cells, one quotient bit each. Every stage holds
// its word independently, so bubbles close up under output back-pressure.
// Configuration registers are written through cfg_* and take effect at once;
// cfg_ready is always high.
module argb_rotated_pixel_blend import rpb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [29:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pos_x[11:0], pos_y[23:12], fore_color[55:24], global_alpha[63:56],
  // back_color[95:64]
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // write_enable[0], word_address[30:1], out_color[62:31], zero[63]
  output logic [63:0] m_tdata
);

  logic [AddrW-1:0] frame_base;
  logic [DimW-1:0]  row_pitch, canvas_width, canvas_height;
  logic             rotate_clockwise;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base       <= '0;
      row_pitch        <= DimW'(1);
      rotate_clockwise <= 1'b1;
      canvas_width     <= DimW'(1);
      canvas_height    <= DimW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_BASE: frame_base       <= cfg_data;
        REG_ROW_PITCH:  row_pitch        <= cfg_data[DimW-1:0];
        REG_ROTATE_CW:  rotate_clockwise <= cfg_data[0];
        REG_CANVAS_W:   canvas_width     <= cfg_data[DimW-1:0];
        REG_CANVAS_H:   canvas_height    <= cfg_data[DimW-1:0];
        default: ;
      endcase
    end
  end

  logic [11:0] px, py;
  logic [31:0] fc_in, bc_in;
  logic [7:0]  ga;
  assign px    = s_tdata[11:0];
  assign py    = s_tdata[23:12];
  assign fc_in = s_tdata[55:24];
  assign ga    = s_tdata[63:56];
  assign bc_in = s_tdata[95:64];

  // stage 1: alpha product, rotated row/column
  logic v1, r1;
  logic [NumW-1:0]  pa1;
  logic [AddrW-1:0] row1, col1;
  logic [31:0]      fc1, bc1;
  // stage 2: scaled alpha, pitch*row
  logic v2, r2;
  logic [ChanW-1:0] fa2;
  logic [AddrW-1:0] prod2, col2;
  logic [31:0]      fc2, bc2;
  // stage 3: address, fa*ba
  logic v3, r3;
  logic [ChanW-1:0] fa3;
  logic [AddrW-1:0] addr3;
  logic [NumW-1:0]  fb3;
  logic [31:0]      fc3, bc3;
  // stage 4: output alpha and background weight
  logic v4, r4;
  logic [ChanW-1:0] fa4, oa4, bw4;
  logic [AddrW-1:0] addr4;
  logic [31:0]      fc4, bc4;
  // stage 5: divider input
  logic v5, r5;
  rpb_div_t w5;

  logic [ChanW-1:0] comb3;
  assign comb3 = div255(fb3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      if (s_tready) v1 <= s_tvalid;
      if (r1)       v2 <= v1;
      if (r2)       v3 <= v2;
      if (r3)       v4 <= v3;
      if (r4)       v5 <= v4;
    end
    if (s_tready) begin
      pa1 <= NumW'(fc_in[31:24] * ga);
      if (rotate_clockwise) begin
        col1 <= AddrW'(py);
        row1 <= AddrW'(canvas_width) - AddrW'(px) - AddrW'(1);
      end else begin
        col1 <= AddrW'(canvas_height) - AddrW'(py) - AddrW'(1);
        row1 <= AddrW'(px);
      end
      fc1 <= fc_in;
      bc1 <= bc_in;
    end
    if (r1) begin
      fa2   <= div255(pa1);
      prod2 <= AddrW'(row_pitch * row1);
      col2  <= col1;
      fc2   <= fc1;
      bc2   <= bc1;
    end
    if (r2) begin
      fa3   <= fa2;
      addr3 <= frame_base + prod2 + col2;
      fb3   <= NumW'(fa2 * bc2[31:24]);
      fc3   <= fc2;
      bc3   <= bc2;
    end
    if (r3) begin
      fa4   <= fa3;
      oa4   <= fa3 + bc3[31:24] - comb3;
      bw4   <= bc3[31:24] - comb3;
      addr4 <= addr3;
      fc4   <= fc3;
      bc4   <= bc3;
    end
    if (r4) begin
      w5.we     <= (fa4 != '0);
      w5.opaque <= (fa4 == 8'hff);
      w5.addr   <= addr4;
      w5.fc     <= fc4;
      w5.oa     <= oa4;
      w5.quo    <= '0;
      for (int c = 0; c < 3; c++) begin
        w5.rem[c] <= NumW'(fc4[8*c +: 8] * fa4) + NumW'(bc4[8*c +: 8] * bw4);
      end
    end
  end

  // division chain, quotient bit 7 first
  logic     cv [9];
  logic     cr [9];
  rpb_div_t cw [9];

  assign cv[0] = v5;
  assign cw[0] = w5;
  assign r5    = cr[0];

  for (genvar i = 0; i < 8; i++) begin : g_cell
    rpb_div_cell #(.BIT(7 - i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_word   (cw[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_word  (cw[i+1])
    );
  end

  assign cr[8] = m_tready;

  assign r4       = !v5 || r5;
  assign r3       = !v4 || r4;
  assign r2       = !v3 || r3;
  assign r1       = !v2 || r2;
  assign s_tready = !v1 || r1;

  logic [31:0] color;
  always_comb begin
    if (cw[8].opaque) begin
      color = cw[8].fc;
    end else begin
      color = {cw[8].oa, cw[8].quo[2], cw[8].quo[1], cw[8].quo[0]};
    end
  end

  assign m_tvalid = cv[8];
  assign m_tdata  = cw[8].we ? {1'b0, color, cw[8].addr, 1'b1} : 64'd0;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the rotated ARGB pixel blender: directed corner
// pixels, then random pixels under several register settings, with random
// idling on both sides and one long output stall. Every result word is
// checked against an in-bench model of the blend and the rotated address.
// ----------------------------------------------------------------------------
module tb_top import rpb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        we;
    logic [29:0] addr;
    logic [31:0] color;
  } blend_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_FRAME_BASE;
  logic [29:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // pos_x, pos_y, fore_color, global_alpha, back_color
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // write_enable, word_address, out_color, zero
  logic [63:0] m_tdata;

  // model copy of the registers
  logic [29:0] base_q = '0;
  logic [12:0] pitch_q = 13'd1;
  logic        cw_q = 1'b1;
  logic [12:0] width_q = 13'd1;
  logic [12:0] height_q = 13'd1;

  blend_res_t  pending_pixels[$];
  int          errors = 0;
  int          results_seen = 0;
  int          cycle = 0;
  int          stall_hold = 0;
  bit          stall_req = 1'b0;
  bit          stall_used = 1'b0;
  bit          rx_random = 1'b1;

  argb_rotated_pixel_blend i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic blend_res_t blend_pixel(logic [11:0] px, logic [11:0] py,
                                             logic [31:0] fc, logic [7:0] ga,
                                             logic [31:0] bc);
    blend_res_t  r;
    logic [31:0] fa, ba, comb, oa, bw, col, row;
    logic [31:0] ch[3];
    fa = (32'(fc[31:24]) * 32'(ga)) / 255;
    r = '0;
    if (fa == 0) return r;
    if (cw_q) begin
      col = 32'(py);
      row = 32'(width_q) - 32'(px) - 1;
    end else begin
      col = 32'(height_q) - 32'(py) - 1;
      row = 32'(px);
    end
    r.we = 1'b1;
    r.addr = 30'(32'(base_q) + 32'(pitch_q) * row + col);
    if (fa == 255) begin
      r.color = fc;
    end else begin
      ba = 32'(bc[31:24]);
      comb = (fa * ba) / 255;
      oa = fa + ba - comb;
      bw = ba - comb;
      for (int i = 0; i < 3; i++)
        ch[i] = (32'(fc[8*i +: 8]) * fa + 32'(bc[8*i +: 8]) * bw) / oa;
      r.color = {oa[7:0], ch[2][7:0], ch[1][7:0], ch[0][7:0]};
    end
    return r;
  endfunction

  // short gaps mostly, long ones rarely
  function automatic int idle_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // valid stays up from one word to the next unless a gap is drawn
  task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic [31:0] fc,
                            logic [7:0] ga, logic [31:0] bc, bit gaps);
    int n;
    n = gaps ? idle_len() : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {bc, ga, fc, py, px};
    pending_pixels.push_back(blend_pixel(px, py, fc, ga, bc));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [29:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      REG_FRAME_BASE: base_q = val;
      REG_ROW_PITCH:  pitch_q = val[12:0];
      REG_ROTATE_CW:  cw_q = val[0];
      REG_CANVAS_W:   width_q = val[12:0];
      REG_CANVAS_H:   height_q = val[12:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic load_setting(logic [29:0] b, logic [12:0] p, logic c,
                              logic [12:0] w, logic [12:0] h);
    drain();
    write_reg(REG_FRAME_BASE, b);
    write_reg(REG_ROW_PITCH, 30'(p));
    write_reg(REG_ROTATE_CW, 30'(c));
    write_reg(REG_CANVAS_W, 30'(w));
    write_reg(REG_CANVAS_H, 30'(h));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    load_setting(30'h3FFF_FFFF, 13'd4096, 1'b1, 13'd4096, 13'd4096);
    send_pixel(12'd0, 12'd0, 32'hFF12_3456, 8'hFF, 32'h0, 0);       // opaque
    send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 8'hFF, '1, 0);
    send_pixel(12'd5, 12'd7, 32'h00FF_FFFF, 8'hFF, '1, 0);          // transparent
    send_pixel(12'd5, 12'd7, 32'hFFFF_FFFF, 8'h00, '1, 0);
    send_pixel(12'd1, 12'd2, 32'h01AB_CDEF, 8'hFF, 32'h0011_2233, 0);
    send_pixel(12'd1, 12'd2, 32'hFE80_8080, 8'hFF, 32'hFF00_0000, 0);
    send_pixel(12'd3, 12'd4, 32'h80FF_0000, 8'h80, 32'h0000_0000, 0); // bg clear
    send_pixel(12'd3, 12'd4, 32'hFF00_FF00, 8'h01, 32'h01FF_FFFF, 0); // scaled to 1
    send_pixel(12'd9, 12'd9, 32'h7F12_3456, 8'hFE, 32'hFFAB_CDEF, 0);
    load_setting(30'd0, 13'd1, 1'b0, 13'd1, 13'd1);
    send_pixel(12'hFFF, 12'hFFF, 32'hFFAA_5500, 8'hFF, 32'h0, 0);   // off canvas
    send_pixel(12'd0, 12'd0, 32'h40FF_FFFF, 8'hFF, 32'hC000_0000, 0);
    load_setting(30'h1234_5678, 13'd0, 1'b1, 13'd0, 13'd0);         // zero sizes
    send_pixel(12'd7, 12'd3, 32'hFF01_0203, 8'hFF, 32'h0, 0);
    load_setting(30'h1234_5678, 13'd0, 1'b0, 13'd0, 13'd0);
    send_pixel(12'd7, 12'd3, 32'hFF01_0203, 8'hFF, 32'h0, 0);
  endtask

  task automatic random_pixel(bit gaps);
    logic [31:0] fc;
    logic [7:0]  ga;
    logic [31:0] bc;
    fc = $urandom;
    bc = $urandom;
    ga = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
    if ($urandom_range(9) == 0) fc[31:24] = 8'hFF;
    send_pixel(12'($urandom), 12'($urandom), fc, ga, bc, gaps);
  endtask

  task automatic test_random();
    for (int s = 0; s < 4; s++) begin
      load_setting(30'($urandom), 13'($urandom_range(4096, 1)), 1'($urandom),
                   13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)));
      for (int i = 0; i < 220; i++) random_pixel(i >= 40);
    end
  endtask

  // sink stalls for a long stretch while the source keeps pushing
  task automatic test_backpressure();
    drain();
    rx_random = 1'b0;
    stall_req = 1'b1;
    for (int i = 0; i < 60; i++) random_pixel(0);
    rx_random = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_req && !stall_used) begin
      m_tready <= 1'b0;
      stall_hold <= 200;
      stall_used <= 1'b1;
    end else if (stall_hold > 0) begin
      m_tready <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else if (!rx_random) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) < 70) || (cycle % 300 < 60);
    end
  end

  always @(posedge clk) begin
    blend_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_tdata);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (m_tdata[0] !== e.we) begin
          $display("%0t: write_enable exp %b got %b", $time, e.we, m_tdata[0]);
          errors++;
        end
        if (m_tdata[30:1] !== e.addr) begin
          $display("%0t: word_address exp %h got %h", $time, e.addr, m_tdata[30:1]);
          errors++;
        end
        if (m_tdata[62:31] !== e.color) begin
          $display("%0t: out_color exp %h got %h", $time, e.color, m_tdata[62:31]);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    drain();
    $display("covered %0d result words: corner pixels, eight register settings,",
             results_seen);
    $display("back-to-back and random idling on both sides, a long output stall");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/rpb_pkg.sv
src/rpb_div_cell.sv
src/argb_rotated_pixel_blend.sv
verif/tb_top.sv
